// ===== rtl/msha_pkg.sv =====
// ----------------------------------------------------------------------------
// msha_pkg
// Shared types, constants and round functions for the 16-bit hash engine.
// ----------------------------------------------------------------------------
package msha_pkg;

   // Block geometry and the round count.
   localparam int WORDS_PER_BLOCK = 8;
   localparam int BYTES_PER_BLOCK = 16;
   localparam int ROUNDS          = 32;

   // Padding constants.
   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [3:0] LEN_SPLIT = 4'd14;

   // Eight 16-bit words, index 0 first.
   typedef logic [WORDS_PER_BLOCK-1:0][15:0] word_array_type;

   // Commands from the sequencer to the compression unit.
   typedef struct packed {
      logic start;
      logic reinit;
   } msha_cmd_type;

   // Initial chaining value.
   function automatic logic [15:0] init_word(input logic [2:0] idx);
      logic [15:0] w;
      case (idx)
         3'd0:    w = 16'h6a09;
         3'd1:    w = 16'hbb67;
         3'd2:    w = 16'h3c6e;
         3'd3:    w = 16'ha54f;
         3'd4:    w = 16'h510e;
         3'd5:    w = 16'h9b05;
         3'd6:    w = 16'h1f83;
         default: w = 16'h5be0;
      endcase
      return w;
   endfunction

   // Round constant table.
   function automatic logic [15:0] round_const(input logic [4:0] idx);
      logic [15:0] k;
      case (idx)
         5'd0:    k = 16'h428a;
         5'd1:    k = 16'h7137;
         5'd2:    k = 16'hb5c0;
         5'd3:    k = 16'he9b5;
         5'd4:    k = 16'h3956;
         5'd5:    k = 16'h59f1;
         5'd6:    k = 16'h923f;
         5'd7:    k = 16'hab1c;
         5'd8:    k = 16'hd807;
         5'd9:    k = 16'h1283;
         5'd10:   k = 16'h2431;
         5'd11:   k = 16'h550c;
         5'd12:   k = 16'h72be;
         5'd13:   k = 16'h80de;
         5'd14:   k = 16'h9bdc;
         5'd15:   k = 16'hc19b;
         5'd16:   k = 16'he49b;
         5'd17:   k = 16'hefbe;
         5'd18:   k = 16'h0fc1;
         5'd19:   k = 16'h240c;
         5'd20:   k = 16'h2de9;
         5'd21:   k = 16'h4a74;
         5'd22:   k = 16'h5cb0;
         5'd23:   k = 16'h76f9;
         5'd24:   k = 16'h983e;
         5'd25:   k = 16'ha831;
         5'd26:   k = 16'hb003;
         5'd27:   k = 16'hbf59;
         5'd28:   k = 16'hc6e0;
         5'd29:   k = 16'hd5a7;
         5'd30:   k = 16'h06ca;
         default: k = 16'h1429;
      endcase
      return k;
   endfunction

   // Rotate a 16-bit word right by a fixed amount.
   function automatic logic [15:0] ror16(input logic [15:0] v, input int n);
      return (v >> n) | (v << (16 - n));
   endfunction

   function automatic logic [15:0] big_sig0(input logic [15:0] v);
      return ror16(v, 1) ^ ror16(v, 6) ^ ror16(v, 11);
   endfunction

   function automatic logic [15:0] big_sig1(input logic [15:0] v);
      return ror16(v, 3) ^ ror16(v, 5) ^ ror16(v, 12);
   endfunction

   function automatic logic [15:0] small_sig0(input logic [15:0] v);
      return ror16(v, 3) ^ ror16(v, 7) ^ (v >> 1);
   endfunction

   function automatic logic [15:0] small_sig1(input logic [15:0] v);
      return ror16(v, 8) ^ ror16(v, 9) ^ (v >> 5);
   endfunction

endpackage

// ===== rtl/msha_compress.sv =====
// ----------------------------------------------------------------------------
// msha_compress
// Iterative compression unit: one shared round datapath used for 32 rounds,
// followed by the feed-forward add into the chaining state.
// ----------------------------------------------------------------------------
module msha_compress (
   input  logic                    clock,
   input  logic                    reset,
   input  msha_pkg::msha_cmd_type  cmd,
   input  msha_pkg::word_array_type msg_words,
   output logic                    done,
   output msha_pkg::word_array_type chain_words
);

   msha_pkg::word_array_type chain_ff, chain_in;
   msha_pkg::word_array_type work_ff, work_in;
   msha_pkg::word_array_type sched_ff, sched_in;
   logic [4:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       fin_ff, fin_in;

   logic [15:0] w_new, w_cur, t1, ne, na, ch, maj;

   // Shared round datapath. From round 8 on, the schedule is a shift line holding W[t-8..t-1].
   always_comb begin
      w_new = msha_pkg::small_sig1(sched_ff[6]) + sched_ff[4]
            + msha_pkg::small_sig0(sched_ff[1]) + sched_ff[0];
      w_cur = (round_ff[4:3] == 2'd0) ? sched_ff[0] : w_new;
      ch    = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]);
      t1    = work_ff[7] + msha_pkg::big_sig1(work_ff[4]) + ch
            + msha_pkg::round_const(round_ff) + w_cur;
      ne    = t1 + work_ff[3];
      na    = t1 + msha_pkg::big_sig0(work_ff[0]) + maj;
   end

   // Sequencing of load, rounds and final add.
   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      if (cmd.start) begin
         work_in  = chain_ff;
         sched_in = msg_words;
         round_in = 5'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < msha_pkg::WORDS_PER_BLOCK - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[msha_pkg::WORDS_PER_BLOCK-1] = w_cur;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = ne;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = na;
         round_in   = round_ff + 5'd1;
         if (round_ff == 5'(msha_pkg::ROUNDS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         for (int i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.reinit) begin
         for (int i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
            chain_in[i] = msha_pkg::init_word(3'(i));
         end
      end
   end

   // Control state and the chaining value are reset; working data is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= 5'd0;
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         for (int i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
            chain_ff[i] <= msha_pkg::init_word(3'(i));
         end
      end else begin
         round_ff <= round_in;
         busy_ff  <= busy_in;
         fin_ff   <= fin_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign done        = fin_ff;
   assign chain_words = chain_ff;

endmodule

// ===== rtl/mini_sha16_hash_engine_core.sv =====
// A byte that does not fill a block is absorbed directly; one that fills it stalls the
// input while the block is compressed (start, 32 rounds, final add).
// An end-of-message item raises rsp_valid once the padded block, an extra length block
// where needed and any block its byte fills are compressed; eight words follow, one per unstalled cycle.
// Throughput: one round a cycle on the shared datapath.
// Reset (synchronous) loads the initial chaining value and clears counts.
// ----------------------------------------------------------------------------
// mini_sha16_hash_engine_core
// Byte packing, padding sequencer and digest output around the shared
// compression unit.
// ----------------------------------------------------------------------------
module mini_sha16_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BLKGO = 4'd1;
   localparam logic [3:0] S_WAITB = 4'd2;
   localparam logic [3:0] S_PAD   = 4'd3;
   localparam logic [3:0] S_PADGO = 4'd4;
   localparam logic [3:0] S_WAITP = 4'd5;
   localparam logic [3:0] S_LEN   = 4'd6;
   localparam logic [3:0] S_LENGO = 4'd7;
   localparam logic [3:0] S_WAITL = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;
   logic [15:0] bit_length_ff, bit_length_in;
   logic        eom_ff, eom_in;
   logic [2:0]  idx_ff, idx_in;
   logic [msha_pkg::BYTES_PER_BLOCK-1:0][7:0] store_ff, store_in;

   msha_pkg::msha_cmd_type   cmd;
   msha_pkg::word_array_type msg_words;
   msha_pkg::word_array_type chain_words;
   logic                     comp_done;
   logic                     req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // Pack the block bytes big-endian into words.
   always_comb begin
      for (int i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
         msg_words[i] = {store_ff[2*i], store_ff[2*i+1]};
      end
   end

   msha_compress u_compress (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_words   (msg_words),
      .done        (comp_done),
      .chain_words (chain_words)
   );

   // Sequencer: absorb bytes, pad, append the length and emit the digest.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      bit_length_in = bit_length_ff;
      eom_in        = eom_ff;
      idx_in        = idx_ff;
      store_in      = store_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               eom_in = req_end_of_message;
               if (req_byte_valid) begin
                  store_in[fill_ff] = req_data_byte;
                  bit_length_in     = bit_length_ff + 16'd8;
                  fill_in           = fill_ff + 4'd1;
                  if (fill_ff == 4'(msha_pkg::BYTES_PER_BLOCK - 1)) begin
                     state_in = S_BLKGO;
                  end else if (req_end_of_message) begin
                     state_in = S_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_BLKGO: begin
            cmd.start = 1'b1;
            state_in  = S_WAITB;
         end
         S_WAITB: begin
            if (comp_done) begin
               state_in = eom_ff ? S_PAD : S_IDLE;
            end
         end
         S_PAD: begin
            for (int i = 0; i < msha_pkg::BYTES_PER_BLOCK; i++) begin
               if (5'(i) == {1'b0, fill_ff}) begin
                  store_in[i] = msha_pkg::PAD_BYTE;
               end else if (5'(i) > {1'b0, fill_ff}) begin
                  store_in[i] = 8'h00;
               end
            end
            state_in = S_PADGO;
         end
         S_PADGO: begin
            if (fill_ff >= msha_pkg::LEN_SPLIT) begin
               cmd.start = 1'b1;
               state_in  = S_WAITP;
            end else begin
               state_in = S_LEN;
            end
         end
         S_WAITP: begin
            if (comp_done) begin
               store_in = '0;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            store_in[msha_pkg::BYTES_PER_BLOCK-2] = bit_length_ff[15:8];
            store_in[msha_pkg::BYTES_PER_BLOCK-1] = bit_length_ff[7:0];
            state_in = S_LENGO;
         end
         S_LENGO: begin
            cmd.start = 1'b1;
            state_in  = S_WAITL;
         end
         S_WAITL: begin
            if (comp_done) begin
               idx_in   = 3'd0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'(msha_pkg::WORDS_PER_BLOCK - 1)) begin
                  cmd.reinit    = 1'b1;
                  fill_in       = 4'd0;
                  bit_length_in = 16'd0;
                  eom_in        = 1'b0;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= 4'd0;
         bit_length_ff <= 16'd0;
         eom_ff        <= 1'b0;
         idx_ff        <= 3'd0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bit_length_ff <= bit_length_in;
         eom_ff        <= eom_in;
         idx_ff        <= idx_in;
      end
   end

   // Block byte store needs no reset.
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   // Handshake and result item.
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_digest_word = chain_words[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'(msha_pkg::WORDS_PER_BLOCK - 1));

`ifndef SYNTHESIS
   // A byte that completes a block hands over to the compression start.
   a_block_full: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_byte_valid && fill_ff == 4'd15 |=> state_ff == S_BLKGO && fill_ff == 4'd0)
      else $error("full block did not start compression");

   // The compression unit only finishes while the sequencer waits for it.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      comp_done |-> state_ff == S_WAITB || state_ff == S_WAITP || state_ff == S_WAITL)
      else $error("compression finished outside a wait state");

   // After the last digest item the message state is cleared.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_last_word |=> state_ff == S_IDLE && fill_ff == 4'd0
                                   && bit_length_ff == 16'd0)
      else $error("message state not cleared after digest");
`endif

endmodule

// ===== dv/mini_sha16_hash_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// mini_sha16_hash_engine_core_tb
// Self-checking bench for the 16-bit hash engine. Message bytes are offered
// on the request channel, first from a short directed table and then as
// random messages. A predictor in the bench computes the digest of every
// message, and each digest word that leaves the block is compared with it.
// ----------------------------------------------------------------------------
module mini_sha16_hash_engine_core_tb;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 100;
   localparam int MAX_REPORTS      = 10;

   // Initial chaining value and round constants, index 0 first.
   localparam logic [0:7][15:0] IV_WORDS = {
      16'h6a09, 16'hbb67, 16'h3c6e, 16'ha54f, 16'h510e, 16'h9b05, 16'h1f83, 16'h5be0
   };
   localparam logic [0:31][15:0] ROUND_K = {
      16'h428a, 16'h7137, 16'hb5c0, 16'he9b5, 16'h3956, 16'h59f1, 16'h923f, 16'hab1c,
      16'hd807, 16'h1283, 16'h2431, 16'h550c, 16'h72be, 16'h80de, 16'h9bdc, 16'hc19b,
      16'he49b, 16'hefbe, 16'h0fc1, 16'h240c, 16'h2de9, 16'h4a74, 16'h5cb0, 16'h76f9,
      16'h983e, 16'ha831, 16'hb003, 16'hbf59, 16'hc6e0, 16'hd5a7, 16'h06ca, 16'h1429
   };

   // Directed items, each packed as {byte_valid, end_of_message, data_byte}.
   localparam int DIRECTED_COUNT = 22;
   localparam logic [0:DIRECTED_COUNT-1][9:0] DIRECTED_ITEMS = {
      // Empty message: an end marker with no byte.
      {1'b0, 1'b1, 8'h00},
      // One-byte messages at both extremes, byte and end together.
      {1'b1, 1'b1, 8'h00},
      {1'b1, 1'b1, 8'hff},
      // An item with neither byte nor end is ignored.
      {1'b0, 1'b0, 8'ha5},
      // Fourteen bytes leave no room for the length, so an extra block follows.
      {1'b1, 1'b0, 8'hff}, {1'b1, 1'b0, 8'h00}, {1'b1, 1'b0, 8'hff},
      {1'b1, 1'b0, 8'h00}, {1'b1, 1'b0, 8'h80}, {1'b1, 1'b0, 8'h7f},
      {1'b1, 1'b0, 8'h01}, {1'b1, 1'b0, 8'hfe}, {1'b1, 1'b0, 8'h55},
      {1'b1, 1'b0, 8'haa}, {1'b1, 1'b0, 8'h00}, {1'b1, 1'b0, 8'hff},
      {1'b1, 1'b0, 8'h12},
      {1'b0, 1'b0, 8'hff},
      {1'b1, 1'b1, 8'h34},
      // A short message closed by a separate end marker.
      {1'b1, 1'b0, 8'h61}, {1'b1, 1'b0, 8'h62}, {1'b0, 1'b1, 8'h00}
   };

   // One expected digest word.
   typedef struct packed {
      logic [15:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_byte_valid     = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [15:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Predictor state: chaining words, pending block bytes, fill and bit count.
   logic [15:0] hash_chain [msha_pkg::WORDS_PER_BLOCK];
   logic [7:0]  hash_block [msha_pkg::BYTES_PER_BLOCK];
   logic [3:0]  hash_fill;
   logic [15:0] hash_bits;

   digest_word_type digest_expected_q [$];

   int unsigned mismatch_count = 0;
   int unsigned items_accepted = 0;
   logic        quiet_phase    = 1'b0;
   logic        hold_wanted    = 1'b0;
   logic        hold_taken;
   int unsigned stall_left;
   int unsigned hold_left;

   mini_sha16_hash_engine_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic logic [15:0] rotr16(input logic [15:0] v, input int unsigned n);
      logic [31:0] twice;
      twice = {v, v} >> n;
      return twice[15:0];
   endfunction

   function automatic logic [15:0] sum_a(input logic [15:0] v);
      return rotr16(v, 1) ^ rotr16(v, 6) ^ rotr16(v, 11);
   endfunction

   function automatic logic [15:0] sum_e(input logic [15:0] v);
      return rotr16(v, 3) ^ rotr16(v, 5) ^ rotr16(v, 12);
   endfunction

   function automatic logic [15:0] mix_lo(input logic [15:0] v);
      return rotr16(v, 3) ^ rotr16(v, 7) ^ {1'b0, v[15:1]};
   endfunction

   function automatic logic [15:0] mix_hi(input logic [15:0] v);
      return rotr16(v, 8) ^ rotr16(v, 9) ^ {5'b0, v[15:5]};
   endfunction

   // Compress the sixteen pending bytes into the chaining words.
   function automatic void compress_block();
      logic [15:0] win [8];
      logic [15:0] wv [8];
      logic [15:0] w;
      logic [15:0] t1;
      logic [15:0] t2;
      int          i;
      int          r;
      for (i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
         win[i] = {hash_block[2 * i], hash_block[2 * i + 1]};
         wv[i]  = hash_chain[i];
      end
      for (r = 0; r < msha_pkg::ROUNDS; r++) begin
         if (r < msha_pkg::WORDS_PER_BLOCK) begin
            w = win[r];
         end else begin
            // The window holds the last eight schedule words, modulo eight.
            w = mix_hi(win[(r - 2) & 7]) + win[(r - 4) & 7] + mix_lo(win[(r - 7) & 7]) +
                win[r & 7];
            win[r & 7] = w;
         end
         t1 = wv[7] + sum_e(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[r] + w;
         t2 = sum_a(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
         wv[7] = wv[6];
         wv[6] = wv[5];
         wv[5] = wv[4];
         wv[4] = wv[3] + t1;
         wv[3] = wv[2];
         wv[2] = wv[1];
         wv[1] = wv[0];
         wv[0] = t1 + t2;
      end
      for (i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) hash_chain[i] = hash_chain[i] + wv[i];
   endfunction

   function automatic void hash_restart();
      int i;
      for (i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) hash_chain[i] = IV_WORDS[i];
      hash_fill = '0;
      hash_bits = '0;
   endfunction

   // Absorb one accepted item; at the end of a message queue its digest.
   function automatic void predict_item(input logic [7:0] data, input logic has_byte,
                                        input logic is_end);
      digest_word_type dw;
      int              i;
      if (has_byte) begin
         hash_block[hash_fill] = data;
         hash_bits = hash_bits + 16'd8;
         if (hash_fill == 4'd15) begin
            compress_block();
            hash_fill = '0;
         end else begin
            hash_fill = hash_fill + 4'd1;
         end
      end
      if (is_end) begin
         hash_block[hash_fill] = msha_pkg::PAD_BYTE;
         for (i = hash_fill + 1; i < msha_pkg::BYTES_PER_BLOCK; i++) hash_block[i] = 8'h00;
         // No room for the length: flush and start a block of zeros.
         if (hash_fill >= msha_pkg::LEN_SPLIT) begin
            compress_block();
            for (i = 0; i < msha_pkg::BYTES_PER_BLOCK; i++) hash_block[i] = 8'h00;
         end
         hash_block[msha_pkg::BYTES_PER_BLOCK - 2] = hash_bits[15:8];
         hash_block[msha_pkg::BYTES_PER_BLOCK - 1] = hash_bits[7:0];
         compress_block();
         for (i = 0; i < msha_pkg::WORDS_PER_BLOCK; i++) begin
            dw.word  = hash_chain[i];
            dw.index = i[2:0];
            dw.last  = (i == msha_pkg::WORDS_PER_BLOCK - 1);
            digest_expected_q.push_back(dw);
         end
         hash_restart();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one item, wait until it is taken, then perhaps leave a short gap.
   task automatic push_item(input logic [7:0] data, input logic has_byte, input logic is_end);
      int unsigned gap;
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_byte_valid     <= has_byte;
      req_end_of_message <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(data, has_byte, is_end);
      if (has_byte || is_end) items_accepted++;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One message of random bytes, with the odd ignored item mixed in.
   task automatic send_message(input int unsigned len, input bit end_with_byte);
      int unsigned k;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         push_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (k == len - 1));
      end
      if (!end_with_byte || len == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Mostly whole messages, lengths biased to the block boundaries, plus noise.
   task automatic random_messages(input int unsigned count);
      int unsigned target;
      int unsigned len;
      int unsigned pick;
      target = items_accepted + count;
      while (items_accepted < target) begin
         if ($urandom_range(0, 9) == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               len = $urandom_range(0, 20);
            end else if (pick < 9) begin
               case ($urandom_range(0, 5))
                  0:       len = 13;
                  1:       len = 14;
                  2:       len = 15;
                  3:       len = 16;
                  4:       len = 31;
                  default: len = 32;
               endcase
            end else begin
               len = $urandom_range(21, 48);
            end
            send_message(len, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall bursts and one long hold-off
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_wanted && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD_CYCLES;
         stall_left <= 0;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else if (stall_left > 1) begin
         hold_left  <= 0;
         stall_left <= stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         hold_left  <= 0;
         stall_left <= $urandom_range(1, 4);
         rsp_stall  <= 1'b1;
      end else begin
         hold_left  <= 0;
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Digest checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
   endtask

   always @(posedge clock) begin : check_digest
      digest_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_expected_q.size() == 0) begin
            report_mismatch("digest word with none pending", 0, 32'(rsp_digest_word));
         end else begin
            want = digest_expected_q.pop_front();
            if (rsp_digest_word !== want.word)
               report_mismatch("digest_word", 32'(want.word), 32'(rsp_digest_word));
            if (rsp_word_index !== want.index)
               report_mismatch("word_index", 32'(want.index), 32'(rsp_word_index));
            if (rsp_last_word !== want.last)
               report_mismatch("last_word", 32'(want.last), 32'(rsp_last_word));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin : main_sequence
      int i;
      hash_restart();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (i = 0; i < DIRECTED_COUNT; i++)
         push_item(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][9], DIRECTED_ITEMS[i][8]);

      random_messages(130);

      // Long receiver hold-off while messages keep coming, so the input stalls.
      hold_wanted <= 1'b1;
      random_messages(20);

      // Sender waits for every pending digest word before going on.
      req_valid <= 1'b0;
      while (digest_expected_q.size() != 0) @(posedge clock);

      random_messages(100);

      // Final part with no idling on either side.
      quiet_phase <= 1'b1;
      random_messages(60);
      req_valid <= 1'b0;

      while (digest_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
